// File: hdl/prafb_pkg.sv
// package for the page run allocator: sizes, status codes, ctrl/datapath structs
// no dependencies
package prafb_pkg;
  localparam int HEAP_PAGES_DEF  = 1024;
  localparam int MAX_RECORDS_DEF = 256;
  localparam int PAGE_BYTES_DEF  = 4096;

  localparam int PAGE_W  = 10;
  localparam int LEN_W   = 11;
  localparam int BYTES_W = 23;
  localparam int ST_W    = 3;

  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_SPACE   = 3'd1;
  localparam logic [ST_W-1:0] ST_ZERO_SIZE  = 3'd2;
  localparam logic [ST_W-1:0] ST_TABLE_FULL = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_FOUND  = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic load;       // capture request, clear counters
    logic scan;       // one bitmap step
    logic mark;       // one page write step
    logic search;     // one record read step
    logic shift;      // one compaction step
    logic append;     // write new record
    logic dec_count;  // drop a record
    logic set_status; // latch status code
    logic [ST_W-1:0] status;
  } prafb_cmd_t;

  typedef struct packed {
    logic init_busy;  // bitmap clearing pass after reset
    logic zero_size;
    logic table_full;
    logic too_big;
    logic scan_done;
    logic found_run;
    logic first_hit;  // first fit may stop
    logic mark_done;
    logic search_done;
    logic rec_hit;
    logic shift_done;
  } prafb_stat_t;
endpackage

// File: hdl/prafb_ctrl.sv
// controller state machine for the page run allocator
// depends on prafb_pkg
module prafb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  logic                  in_op,
  input  logic                  out_busy,
  input  logic                  fit_strategy,
  input  prafb_pkg::prafb_stat_t stat,
  output prafb_pkg::prafb_cmd_t  cmd,
  output logic                  idle,
  output logic                  result_push
);
  import prafb_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_MARK  = 4'd3;
  localparam logic [3:0] S_FIND  = 4'd4;
  localparam logic [3:0] S_FWAIT = 4'd5;
  localparam logic [3:0] S_CLEAR = 4'd6;
  localparam logic [3:0] S_SHIFT = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_FCHK  = 4'd9;

  logic [3:0] state, state_next;
  logic op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_ALLOC;
    end else begin
      state <= state_next;
      if (in_fire) op <= in_op;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    result_push = 1'b0;
    idle        = (state == S_IDLE) && !stat.init_busy;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = in_op == OP_ALLOC ? S_CHECK : S_FIND;
        end
      end
      S_CHECK: begin
        cmd.set_status = 1'b1;
        if (stat.zero_size) begin
          cmd.status = ST_ZERO_SIZE; state_next = S_DONE;
        end else if (stat.table_full) begin
          cmd.status = ST_TABLE_FULL; state_next = S_DONE;
        end else if (stat.too_big) begin
          cmd.status = ST_NO_SPACE; state_next = S_DONE;
        end else begin
          cmd.status = ST_OK; state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.first_hit && !fit_strategy) begin
          state_next = S_MARK;
        end else if (stat.scan_done) begin
          if (stat.found_run) begin
            state_next = S_MARK;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_NO_SPACE;
            state_next     = S_DONE;
          end
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_MARK: begin
        if (stat.mark_done) begin
          cmd.append = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.mark = 1'b1;
        end
      end
      S_FIND: begin
        if (stat.search_done) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOT_FOUND;
          state_next     = S_DONE;
        end else begin
          cmd.search = 1'b1;
          state_next = S_FWAIT;
        end
      end
      S_FWAIT: state_next = S_FCHK;  // read data lands
      S_FCHK: begin
        if (stat.rec_hit) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
          state_next     = S_CLEAR;
        end else begin
          state_next = S_FIND;
        end
      end
      S_CLEAR: begin
        if (stat.mark_done) state_next = S_SHIFT;
        else cmd.mark = 1'b1;
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          cmd.dec_count = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          result_push = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (op == OP_ALLOC && state == S_CLEAR) state_next = S_IDLE;
  end
endmodule

// File: hdl/prafb_dp.sv
// datapath: page bitmap, record memories, scan and search counters
// depends on prafb_pkg
module prafb_dp #(
  parameter int HEAP_PAGES  = prafb_pkg::HEAP_PAGES_DEF,
  parameter int MAX_RECORDS = prafb_pkg::MAX_RECORDS_DEF,
  parameter int PAGE_BYTES  = prafb_pkg::PAGE_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  prafb_pkg::prafb_cmd_t             cmd,
  input  logic                             in_op,
  input  logic [prafb_pkg::BYTES_W-1:0]    in_bytes,
  input  logic [prafb_pkg::PAGE_W-1:0]     in_page,
  output prafb_pkg::prafb_stat_t            stat,
  output logic [prafb_pkg::ST_W-1:0]       res_status,
  output logic [prafb_pkg::PAGE_W-1:0]     res_start,
  output logic [prafb_pkg::LEN_W-1:0]      res_len
);
  import prafb_pkg::*;

  localparam int HP_W  = $clog2(HEAP_PAGES);
  localparam int HC_W  = $clog2(HEAP_PAGES + 1);
  localparam int RI_W  = $clog2(MAX_RECORDS);
  localparam int RC_W  = $clog2(MAX_RECORDS + 1);
  localparam int PB_SH = $clog2(PAGE_BYTES);
  localparam int NEED_W = BYTES_W - PB_SH + 1;

  logic                page_used [HEAP_PAGES];
  logic [PAGE_W-1:0]   rec_start [MAX_RECORDS];
  logic [LEN_W-1:0]    rec_len   [MAX_RECORDS];
  logic [RC_W-1:0]     rec_count;

  logic [BYTES_W-1:0]  bytes;
  logic [PAGE_W-1:0]   page;
  logic [NEED_W-1:0]   need;
  logic [HC_W-1:0]     p, run, best_len;
  logic [HC_W-1:0]     best_start;
  logic                found;
  logic [HC_W-1:0]     mcnt;
  logic [LEN_W-1:0]    mlen;
  logic                mval;
  logic [RC_W-1:0]     ri;
  logic [PAGE_W-1:0]   rd_start;
  logic [LEN_W-1:0]    rd_len;
  logic                pu_rd;
  logic [HP_W-1:0]     pu_addr;
  logic [HC_W-1:0]     clr_cnt;
  logic                init_busy;
  logic [RI_W-1:0]     sh_addr;
  logic [PAGE_W-1:0]   sh_start;
  logic [LEN_W-1:0]    sh_len;
  logic                take_hit;

  // rounding up to pages is a shift since page size is a power of two
  logic [BYTES_W:0] bytes_up;
  assign bytes_up = {1'b0, bytes} + (BYTES_W+1)'(PAGE_BYTES - 1);
  assign need = NEED_W'(bytes_up >> PB_SH);

  // bitmap read is registered: fetch the page the scan looks at next
  assign pu_addr = cmd.scan ? HP_W'(p + 1'b1) : p[HP_W-1:0];

  // compaction reads one entry ahead of the write
  assign sh_addr = cmd.shift ? RI_W'(ri + 2'd2) : RI_W'(ri + 1'b1);

  // matching record found on a free
  assign take_hit = cmd.set_status && (cmd.status == ST_OK) && stat.rec_hit && !mval;

  logic is_free, closes;
  assign is_free = (p < HC_W'(HEAP_PAGES)) && !pu_rd;
  assign closes  = !is_free && ({{(32-HC_W){1'b0}}, run} >= 32'(need)) &&
                   (!found || run < best_len);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bytes <= in_bytes;
      page  <= in_page;
    end
    if (cmd.set_status) res_status <= cmd.status;
    if (cmd.load) begin
      res_start <= (in_op == OP_FREE) ? in_page : '0;
      res_len   <= '0;
    end
    if (cmd.append) begin
      res_start <= PAGE_W'(best_start);
      res_len   <= LEN_W'(need);
    end
    if (take_hit) res_len <= rd_len;
    if (cmd.search) begin
      rd_start <= rec_start[ri[RI_W-1:0]];
      rd_len   <= rec_len[ri[RI_W-1:0]];
    end
    sh_start <= rec_start[sh_addr];
    sh_len   <= rec_len[sh_addr];
    if (cmd.append) begin
      rec_start[rec_count[RI_W-1:0]] <= PAGE_W'(best_start);
      rec_len[rec_count[RI_W-1:0]]   <= LEN_W'(need);
    end
    if (cmd.shift) begin
      rec_start[ri[RI_W-1:0]] <= sh_start;
      rec_len[ri[RI_W-1:0]]   <= sh_len;
    end
  end

  // page bitmap: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (init_busy) begin
      page_used[clr_cnt[HP_W-1:0]] <= 1'b0;
    end else if (cmd.mark) begin
      if (mval) page_used[HP_W'(best_start + mcnt)] <= 1'b1;
      else page_used[HP_W'(page + mcnt)] <= 1'b0;
    end
    pu_rd <= page_used[pu_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0; init_busy <= 1'b1;
      rec_count <= '0;
      p <= '0; run <= '0; found <= 1'b0; best_len <= '0; best_start <= '0;
      mcnt <= '0; ri <= '0; mval <= 1'b0; mlen <= '0;
    end else begin
      if (init_busy) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == HC_W'(HEAP_PAGES - 1)) init_busy <= 1'b0;
      end
      if (cmd.load) begin
        p <= '0; run <= '0; found <= 1'b0; mcnt <= '0; ri <= '0;
        mval <= (in_op == OP_ALLOC);
      end
      if (cmd.scan) begin
        p <= p + 1'b1;
        if (is_free) run <= run + 1'b1;
        else run <= '0;
        if (closes) begin
          found      <= 1'b1;
          best_len   <= run;
          best_start <= p - run;
        end
      end
      if (cmd.mark) mcnt <= mcnt + 1'b1;
      if (cmd.search) ri <= ri + 1'b1;
      if (take_hit) begin
        ri   <= ri - 1'b1;
        mlen <= rd_len;
      end
      if (cmd.shift) ri <= ri + 1'b1;
      if (cmd.append) rec_count <= rec_count + 1'b1;
      if (cmd.dec_count) rec_count <= rec_count - 1'b1;
    end
  end

  always_comb begin
    stat = '0;
    stat.init_busy  = init_busy;
    stat.zero_size  = (bytes == '0);
    stat.table_full = (rec_count == RC_W'(MAX_RECORDS));
    stat.too_big    = (32'(need) > 32'(HEAP_PAGES));
    stat.scan_done  = (p >= HC_W'(HEAP_PAGES)) && !closes;
    stat.found_run  = found;
    stat.first_hit  = found;
    stat.mark_done  = mval ? (32'(mcnt) >= 32'(need)) : (32'(mcnt) >= 32'(mlen));
    stat.search_done = (ri >= rec_count);
    stat.rec_hit    = (rd_start == page);
    stat.shift_done = (32'(ri) + 1 >= 32'(rec_count));
  end
endmodule

// File: hdl/page_run_allocator_first_best_fit_unit.sv
// top level of the page run allocator: stream ports, config register, output register
// depends on prafb_pkg, prafb_ctrl, prafb_dp
//
// Allocates and frees contiguous page runs over a heap of HEAP_PAGES pages. After reset
// the page bitmap is cleared one page per cycle, and s_axis_tready stays low until the
// clear is done. An allocate item (op 0) rounds request_bytes up to pages and walks
// the page bitmap one page per cycle, taking the first fitting run (fit_strategy 0) or
// the shortest one (1, earliest wins ties), then marks the pages one per cycle and
// appends a record. A free item (op 1) reads the record list one entry at a time through
// the find, wait and check states, clears the run's pages one per cycle and compacts
// later records one per cycle. With best fit an allocate walks the whole bitmap; first
// fit stops the walk in the cycle after the first fitting run closes. A free that finds
// no record walks the whole record list. One item is in work at a time; the result
// waits in an output register. fit_strategy resets to best fit.
module page_run_allocator_first_best_fit_unit #(
  parameter int HEAP_PAGES  = prafb_pkg::HEAP_PAGES_DEF,
  parameter int MAX_RECORDS = prafb_pkg::MAX_RECORDS_DEF,
  parameter int PAGE_BYTES  = prafb_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // request_bytes[22:0], free_page[32:23], zero fill
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // status[2:0], start_page[12:3], run_pages[23:13]
);
  import prafb_pkg::*;

  logic fit_strategy;
  prafb_cmd_t  cmd;
  prafb_stat_t stat;
  logic idle, push, in_fire;
  logic [ST_W-1:0]   r_status;
  logic [PAGE_W-1:0] r_start;
  logic [LEN_W-1:0]  r_len;

  // config register, to be written only while idle; the user must keep to this, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) fit_strategy <= 1'b1;
    else if (cfg_we) fit_strategy <= cfg_wdata;
  end

  assign s_axis_tready = idle;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  prafb_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_op(s_axis_tuser),
    .out_busy(m_axis_tvalid && !m_axis_tready),
    .fit_strategy, .stat, .cmd, .idle, .result_push(push)
  );

  prafb_dp #(.HEAP_PAGES(HEAP_PAGES), .MAX_RECORDS(MAX_RECORDS),
             .PAGE_BYTES(PAGE_BYTES)) u_dp (
    .clk, .rst, .cmd, .in_op(s_axis_tuser),
    .in_bytes(s_axis_tdata[22:0]), .in_page(s_axis_tdata[32:23]),
    .stat, .res_status(r_status), .res_start(r_start), .res_len(r_len)
  );

  // output register: holds the result until taken
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (push) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    if (push) m_axis_tdata <= {r_len, r_start, r_status};
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready) else $error("took item while busy");
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> !(m_axis_tvalid && !m_axis_tready)) else $error("result overwritten");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] != ST_OK && m_axis_tdata[2:0] != ST_NOT_FOUND
    |-> m_axis_tdata[23:13] == '0) else $error("failed allocate with length");
endmodule
